>>> rtl/sobel_edge_magnitude_stream_macros.svh
// ----------------------------------------------------------------------------
// Sobel edge magnitude stream - assertion macros
// Concurrent check wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_MAGNITUDE_STREAM_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_STREAM_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define SEM_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sobel_edge_magnitude_stream check failed");
// next-cycle implication
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sobel_edge_magnitude_stream check failed");
`else
`define SEM_ASSERT_NOW(label, clk, rst, ante, cons)
`define SEM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/sobel_em_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared widths, constants and types.
// ----------------------------------------------------------------------------
package sobel_em_pkg;

  localparam int PIXEL_W        = 8;
  localparam int MAG_W          = 11;
  localparam int CFG_W          = 11;
  localparam int IN_TDATA_W     = 8;
  localparam int OUT_TDATA_W    = 16;
  localparam int MAX_LINE_WIDTH = 1024;

  localparam logic [CFG_W-1:0] LINE_WIDTH_RESET = 11'd32;

  typedef logic [PIXEL_W-1:0] pixel_t;
  typedef logic [MAG_W-1:0]   mag_t;

  // new right-hand column of the window, top to bottom
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } col_t;

endpackage

>>> rtl/sobel_em_ram.sv
// ----------------------------------------------------------------------------
// Line memory
// Simple dual-port RAM, registered read, read-before-write on the same entry.
// ----------------------------------------------------------------------------
module sobel_em_ram #(
  parameter int DEPTH = sobel_em_pkg::MAX_LINE_WIDTH,
  parameter int WIDTH = sobel_em_pkg::PIXEL_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

>>> rtl/sobel_em_window.sv
// ----------------------------------------------------------------------------
// Sobel window and gradient
// 3x3 pixel window shifting left per pixel; |Gx|+|Gy| of the shifted window.
// ----------------------------------------------------------------------------
module sobel_em_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  sobel_em_pkg::col_t  col,
  output sobel_em_pkg::mag_t  mag
);

  // row-major, top row first
  sobel_em_pkg::pixel_t win [9];

  logic [9:0] sum_right, sum_left, sum_bottom, sum_top;
  logic [9:0] gx_abs, gy_abs;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else if (shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= col.top;
      win[3] <= win[4];
      win[4] <= win[5];
      win[5] <= col.mid;
      win[6] <= win[7];
      win[7] <= win[8];
      win[8] <= col.bot;
    end
  end

  // gradients of the window as it stands after this shift
  always_comb begin
    sum_right  = 10'(col.top) + {1'b0, col.mid, 1'b0} + 10'(col.bot);
    sum_left   = 10'(win[1]) + {1'b0, win[4], 1'b0} + 10'(win[7]);
    sum_bottom = 10'(win[7]) + {1'b0, win[8], 1'b0} + 10'(col.bot);
    sum_top    = 10'(win[1]) + {1'b0, win[2], 1'b0} + 10'(col.top);
    gx_abs = (sum_right >= sum_left) ? sum_right - sum_left : sum_left - sum_right;
    gy_abs = (sum_bottom >= sum_top) ? sum_bottom - sum_top : sum_top - sum_bottom;
    mag    = 11'(gx_abs) + 11'(gy_abs);
  end

endmodule

>>> rtl/sobel_edge_magnitude_stream.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude stream
// 3x3 Sobel |Gx|+|Gy| over a raster pixel stream, two RAM line delays.
// ----------------------------------------------------------------------------
// Takes one 8-bit pixel per clock in raster order while the output is not stalled, and
// returns one 11-bit edge magnitude per pixel, in order, through the memory data stage
// and the output register. Throughput is one pixel per clock unless m_axis_tready holds
// the output back, set by the two line memories, each doing one read and one write per
// cycle. The line delays are ring buffers of MAX_LINE_WIDTH entries; line_width (0 taken
// as 1, clamped to MAX_LINE_WIDTH) must be written through the cfg port only while the
// stream is idle, which the block does not enforce. Entries not yet written since reset
// read as zero, tracked by the write pointer having wrapped, so no clearing pass follows
// reset. No border handling: row edges see pixels wrapping from the neighbouring row.
module sobel_edge_magnitude_stream #(
  parameter int MAX_LINE_WIDTH = sobel_em_pkg::MAX_LINE_WIDTH
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // config
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sobel_em_pkg::CFG_W-1:0]        cfg_data,        // line_width
  // pixel in
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [sobel_em_pkg::IN_TDATA_W-1:0]   s_axis_tdata,    // [7:0] pixel
  // magnitude out
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [sobel_em_pkg::OUT_TDATA_W-1:0]  m_axis_tdata     // [10:0] edge_magnitude
);

  `include "sobel_edge_magnitude_stream_macros.svh"

  localparam int AW = $clog2(MAX_LINE_WIDTH);
  localparam int CW = (AW + 1 > sobel_em_pkg::CFG_W) ? AW + 1 : sobel_em_pkg::CFG_W;
  localparam logic [CW-1:0] MAX_C  = CW'(MAX_LINE_WIDTH);
  localparam logic [AW-1:0] LAST_P = AW'(MAX_LINE_WIDTH - 1);

  logic [sobel_em_pkg::CFG_W-1:0] line_width;

  logic [AW-1:0] pos;
  logic          wrapped;
  logic [CW-1:0] w_eff, pos_ext, rd_full;
  logic [AW-1:0] rd_addr;
  logic          rd_ok;
  logic          adv, acc;

  // stage 1: memory data valid
  logic                  s1_valid;
  sobel_em_pkg::pixel_t  px_s1;
  logic [AW-1:0]         pos_s1;
  logic                  ok_s1;
  logic                  fwd_s1;
  sobel_em_pkg::pixel_t  fwd_data;

  sobel_em_pkg::pixel_t  prior_rdata, older_rdata;
  sobel_em_pkg::pixel_t  prior_out, older_out;
  sobel_em_pkg::col_t    col;
  sobel_em_pkg::mag_t    mag;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= sobel_em_pkg::LINE_WIDTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      line_width <= cfg_data;
    end
  end

  // pipeline moves as a whole when the output register can take a result
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // read address, line_width transactions back
  always_comb begin
    if (line_width == '0) begin
      w_eff = CW'(1);
    end else if (CW'(line_width) > MAX_C) begin
      w_eff = MAX_C;
    end else begin
      w_eff = CW'(line_width);
    end
    pos_ext = CW'(pos);
    if (pos_ext >= w_eff) begin
      rd_full = pos_ext - w_eff;
    end else begin
      rd_full = pos_ext + MAX_C - w_eff;
    end
    rd_addr = rd_full[AW-1:0];
    // entries past the write pointer only hold data once it has wrapped
    rd_ok   = wrapped || (pos_ext >= w_eff);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      wrapped <= 1'b0;
    end else if (acc) begin
      if (pos == LAST_P) begin
        pos     <= '0;
        wrapped <= 1'b1;
      end else begin
        pos <= pos + AW'(1);
      end
    end
  end

  sobel_em_ram #(
    .DEPTH (MAX_LINE_WIDTH),
    .WIDTH (sobel_em_pkg::PIXEL_W)
  ) u_prior_ram (
    .clk     (clk),
    .wr_en   (acc),
    .wr_addr (pos),
    .wr_data (s_axis_tdata[sobel_em_pkg::PIXEL_W-1:0]),
    .rd_en   (acc),
    .rd_addr (rd_addr),
    .rd_data (prior_rdata)
  );

  // older row is written from the memory data stage, once the prior row data is back
  sobel_em_ram #(
    .DEPTH (MAX_LINE_WIDTH),
    .WIDTH (sobel_em_pkg::PIXEL_W)
  ) u_older_ram (
    .clk     (clk),
    .wr_en   (s1_valid && adv),
    .wr_addr (pos_s1),
    .wr_data (prior_out),
    .rd_en   (acc),
    .rd_addr (rd_addr),
    .rd_data (older_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      px_s1    <= s_axis_tdata[sobel_em_pkg::PIXEL_W-1:0];
      pos_s1   <= pos;
      ok_s1    <= rd_ok;
      // read hits the older-row write going out this cycle: forward it
      fwd_s1   <= s1_valid && (rd_addr == pos_s1);
      fwd_data <= prior_out;
    end
  end

  assign prior_out = ok_s1 ? prior_rdata : '0;
  assign older_out = fwd_s1 ? fwd_data : (ok_s1 ? older_rdata : '0);

  assign col.top = older_out;
  assign col.mid = prior_out;
  assign col.bot = px_s1;

  sobel_em_window u_window (
    .clk   (clk),
    .rst   (rst),
    .shift (s1_valid && adv),
    .col   (col),
    .mag   (mag)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      m_axis_tdata <= {{(sobel_em_pkg::OUT_TDATA_W - sobel_em_pkg::MAG_W){1'b0}}, mag};
    end
  end

  // forwarding only occurs for a one-pixel line
  `SEM_ASSERT_NOW(a_fwd_unit_width, clk, rst, acc && s1_valid && (rd_addr == pos_s1), w_eff == CW'(1))
  // once wrapped, every ring entry stays written
  `SEM_ASSERT_NEXT(a_wrapped_sticky, clk, rst, wrapped, wrapped)
  // an accepted pixel always reaches the memory data stage
  `SEM_ASSERT_NEXT(a_accept_to_s1, clk, rst, acc, s1_valid)

endmodule
